// ----- hdl/esc2u8_pkg.sv -----
package esc2u8_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U         = 8'h75;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam int unsigned MAX_RESULTS   = 4;
  localparam int unsigned HEX_DIGITS    = 4;

  typedef logic [MAX_RESULTS-1:0][7:0] byte_arr_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] accum;
    logic [2:0]  hex_count;
  } dec_state_t;

  typedef struct packed {
    byte_arr_t  bytes;
    logic [2:0] count;      // 0 to 4 results
    logic       byte_valid; // low only for the empty end marker
    dec_state_t next_state;
  } dec_result_t;

  typedef struct packed {
    byte_arr_t  bytes;
    logic [1:0] len;        // 1 to 3 bytes
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.value = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.value = 4'(b - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp <= 16'h007F) begin
      r.len      = 2'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 16'h07FF) begin
      r.len      = 2'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      r.len      = 2'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ----- hdl/esc2u8_decode.sv -----
module esc2u8_decode
  import esc2u8_pkg::*;
(
  input  dec_state_t  state,
  input  logic [7:0]  in_byte,
  input  logic        string_end,
  output dec_result_t result
);

  hex_t       hex;
  utf8_t      enc_new;
  utf8_t      enc_cur;
  logic [15:0] accum_shift;
  logic [2:0]  count_inc;

  assign hex         = hex_decode(in_byte);
  assign accum_shift = {state.accum[11:0], hex.value};
  assign count_inc   = state.hex_count + 3'd1;
  assign enc_new     = utf8_encode(accum_shift);
  assign enc_cur     = utf8_encode(state.accum);

  always_comb begin
    result            = '0;
    result.byte_valid = 1'b1;
    result.next_state = state;
    unique case (state.mode)
      MODE_HEX: begin
        if (hex.ok) begin
          result.next_state.accum     = accum_shift;
          result.next_state.hex_count = count_inc;
          if (count_inc >= 3'(HEX_DIGITS)) begin
            result.bytes                = enc_new.bytes;
            result.count                = {1'b0, enc_new.len};
            result.next_state.mode      = MODE_PLAIN;
            result.next_state.hex_count = '0;
          end
        end else begin
          // A short run ends: the value so far, then the terminating byte raw.
          result.bytes              = enc_cur.bytes;
          result.bytes[enc_cur.len] = in_byte;
          result.count              = {1'b0, enc_cur.len} + 3'd1;
          result.next_state.mode      = MODE_PLAIN;
          result.next_state.hex_count = '0;
        end
      end
      MODE_ESC: begin
        result.next_state.mode = MODE_PLAIN;
        if (in_byte == CHAR_U) begin
          result.next_state.mode      = MODE_HEX;
          result.next_state.accum     = '0;
          result.next_state.hex_count = '0;
        end else if (in_byte == CHAR_N) begin
          result.bytes[0] = CHAR_LF;
          result.count    = 3'd1;
        end else if (in_byte == CHAR_R) begin
          result.bytes[0] = CHAR_CR;
          result.count    = 3'd1;
        end else begin
          result.bytes[0] = CHAR_BACKSLASH;
          result.bytes[1] = in_byte;
          result.count    = 3'd2;
        end
      end
      default: begin
        if (in_byte == CHAR_BACKSLASH) begin
          result.next_state.mode = MODE_ESC;
        end else begin
          result.next_state.mode = MODE_PLAIN;
          result.bytes[0]        = in_byte;
          result.count           = 3'd1;
        end
      end
    endcase

    if (string_end) begin
      if (result.count == 3'd0) begin
        result.bytes      = '0;
        result.count      = 3'd1;
        result.byte_valid = 1'b0;
      end
      result.next_state.mode      = MODE_PLAIN;
      result.next_state.accum     = '0;
      result.next_state.hex_count = '0;
    end
  end

endmodule

// ----- hdl/escape_to_utf8_decoder_core.sv -----
// Backslash escape decoder producing a UTF-8 byte stream.
//
// The slave channel takes one raw byte per request (s_tdata), with s_tlast
// marking the final byte of a string. The master channel gives one decoded
// byte per request; m_tuser[0] is low only on the empty marker sent when the
// final byte of a string produces no data, m_tuser[1] marks the last result
// caused by one input byte, and m_tlast marks the last result of a string.
//
// An accepted byte sits in an input register and is decoded from there into
// a burst register of up to four result bytes once that register is free;
// the first result is offered straight from the burst register. The burst
// register drains one result per cycle while the receiver is ready and
// reloads in the same cycle its last result is taken.
// After a byte that causes several results, the next byte waits in the input
// register until the single output port has taken them all. Bytes that cause
// no result pass without using the output.
//
// Reset clears the escape state and both registers' valid flags. When the
// receiver stalls, the burst register holds, the input register fills and
// s_tready drops until room opens up.
module escape_to_utf8_decoder_core
  import esc2u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // string_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] last_of_run
  output logic       m_tlast    // end_of_string
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;

  dec_state_t  state;
  dec_result_t result;

  logic        burst_valid;
  byte_arr_t   burst_bytes;
  logic [1:0]  burst_last_idx;
  logic [1:0]  burst_idx;
  logic        burst_byte_valid;
  logic        burst_eos;

  logic        burst_at_end;
  logic        burst_free;
  logic        advance;

  esc2u8_decode u_decode (
    .state      (state),
    .in_byte    (in_byte),
    .string_end (in_last),
    .result     (result)
  );

  assign burst_at_end = (burst_idx == burst_last_idx);
  assign burst_free   = !burst_valid || (m_tready && burst_at_end);
  assign advance      = in_valid && ((result.count == 3'd0) || burst_free);
  assign s_tready     = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode      <= MODE_PLAIN;
      state.accum     <= '0;
      state.hex_count <= '0;
    end else if (advance) begin
      state <= result.next_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      burst_idx   <= '0;
    end else if (advance && result.count != 3'd0) begin
      burst_valid <= 1'b1;
      burst_idx   <= '0;
    end else if (burst_valid && m_tready) begin
      if (burst_at_end) begin
        burst_valid <= 1'b0;
      end
      burst_idx <= burst_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.count != 3'd0) begin
      burst_bytes      <= result.bytes;
      burst_last_idx   <= 2'(result.count - 3'd1);
      burst_byte_valid <= result.byte_valid;
      burst_eos        <= in_last;
    end
  end

  assign m_tvalid = burst_valid;
  assign m_tdata  = burst_bytes[burst_idx];
  assign m_tuser  = {burst_at_end, burst_byte_valid};
  assign m_tlast  = burst_eos && burst_at_end;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    burst_valid |-> burst_idx <= burst_last_idx)
    else $error("burst index ran past the last result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("registers not empty after reset");

  a_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("end of string not on the last result of its byte");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
    else $error("empty marker outside a string end");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> state.mode == MODE_PLAIN && state.hex_count == 3'd0)
    else $error("decoder state not cleared after string end");

endmodule

// ----- bench/escape_to_utf8_decoder_core_test.sv -----
module escape_to_utf8_decoder_core_test
  import esc2u8_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_end;
    logic       str_end;
  } out_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } stim_t;

  // One row of the directed table. When typed is set, the n bytes in d0/d1
  // (with ok as byte_valid of the first) are the expected results.
  typedef struct packed {
    logic [7:0] din;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    logic [7:0] d0;
    logic [7:0] d1;
    logic       ok;
  } row_t;

  localparam int N_ROWS = 25;
  localparam logic [7:0] CHAR_Q = 8'h71;
  localparam logic [7:0] CHAR_Z = 8'h7A;
  localparam logic [7:0] CHAR_BANG = 8'h21;

  localparam row_t ROWS [N_ROWS] = '{
    '{8'h41,          1'b0, 1'b1, 2'd1, 8'h41,   8'h00,  1'b1},
    '{8'h00,          1'b0, 1'b1, 2'd1, 8'h00,   8'h00,  1'b1},
    '{8'hFF,          1'b0, 1'b1, 2'd1, 8'hFF,   8'h00,  1'b1},
    '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,  1'b1},
    '{CHAR_N,         1'b0, 1'b1, 2'd1, CHAR_LF, 8'h00,  1'b1},
    '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,  1'b1},
    '{CHAR_R,         1'b0, 1'b1, 2'd1, CHAR_CR, 8'h00,  1'b1},
    '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,  1'b1},
    '{CHAR_Q,         1'b0, 1'b1, 2'd2, CHAR_BACKSLASH, CHAR_Q, 1'b1},
    // Surrogate code point with mixed-case digits.
    '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,  1'b1},
    '{CHAR_U,         1'b0, 1'b1, 2'd0, 8'h00,   8'h00,  1'b1},
    '{8'h44,          1'b0, 1'b0, 2'd0, 8'h00,   8'h00,  1'b1},
    '{8'h66,          1'b0, 1'b0, 2'd0, 8'h00,   8'h00,  1'b1},
    '{8'h46,          1'b0, 1'b0, 2'd0, 8'h00,   8'h00,  1'b1},
    '{8'h66,          1'b0, 1'b0, 2'd0, 8'h00,   8'h00,  1'b1},
    // A hex run with no digits gives a zero byte and then the raw byte.
    '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,  1'b1},
    '{CHAR_U,         1'b0, 1'b1, 2'd0, 8'h00,   8'h00,  1'b1},
    '{CHAR_Z,         1'b0, 1'b1, 2'd2, 8'h00,   CHAR_Z, 1'b1},
    // Three digits then a terminator: two-byte sequence plus the raw byte.
    '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,  1'b1},
    '{CHAR_U,         1'b0, 1'b1, 2'd0, 8'h00,   8'h00,  1'b1},
    '{8'h37,          1'b0, 1'b0, 2'd0, 8'h00,   8'h00,  1'b1},
    '{8'h66,          1'b0, 1'b0, 2'd0, 8'h00,   8'h00,  1'b1},
    '{8'h46,          1'b0, 1'b0, 2'd0, 8'h00,   8'h00,  1'b1},
    '{CHAR_BANG,      1'b0, 1'b0, 2'd0, 8'h00,   8'h00,  1'b1},
    // A dangling backslash at the end of a string leaves only the marker.
    '{CHAR_BACKSLASH, 1'b1, 1'b1, 2'd1, 8'h00,   8'h00,  1'b0}
  };

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  out_t  expected_q[$];
  int    errors = 0;
  int    burst_left = 0;

  mode_t       dec_mode   = MODE_PLAIN;
  logic [15:0] dec_accum  = '0;
  logic [2:0]  dec_digits = '0;

  escape_to_utf8_decoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("escape_to_utf8_decoder_core verification failed");
    $finish;
  end

  function automatic int hex_digit_value(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    return -1;
  endfunction

  function automatic void add_byte(ref out_t run[$], input logic [7:0] v, input logic ok);
    out_t o;
    o.data    = v;
    o.valid   = ok;
    o.run_end = 1'b0;
    o.str_end = 1'b0;
    run.push_back(o);
  endfunction

  function automatic void add_code_point(ref out_t run[$], input logic [15:0] cp);
    if (cp <= 16'h007F) begin
      add_byte(run, cp[7:0], 1'b1);
    end else if (cp <= 16'h07FF) begin
      add_byte(run, 8'hC0 | {3'b000, cp[10:6]}, 1'b1);
      add_byte(run, 8'h80 | {2'b00, cp[5:0]}, 1'b1);
    end else begin
      add_byte(run, 8'hE0 | {4'b0000, cp[15:12]}, 1'b1);
      add_byte(run, 8'h80 | {2'b00, cp[11:6]}, 1'b1);
      add_byte(run, 8'h80 | {2'b00, cp[5:0]}, 1'b1);
    end
  endfunction

  // Marks the last result of a request, adding the empty marker when the
  // final byte of a string produced nothing.
  function automatic void close_run(ref out_t run[$], input logic fin);
    if (fin && run.size() == 0) add_byte(run, 8'h00, 1'b0);
    if (run.size() > 0) begin
      run[run.size()-1].run_end = 1'b1;
      run[run.size()-1].str_end = fin;
    end
  endfunction

  function automatic void decode_step(input logic [7:0] b, input logic fin, ref out_t run[$]);
    int nib;
    run.delete();
    nib = hex_digit_value(b);
    case (dec_mode)
      MODE_HEX: begin
        if (nib >= 0) begin
          dec_accum  = {dec_accum[11:0], 4'(nib)};
          dec_digits = dec_digits + 3'd1;
          if (dec_digits >= 3'(HEX_DIGITS)) begin
            add_code_point(run, dec_accum);
            dec_mode   = MODE_PLAIN;
            dec_digits = '0;
          end
        end else begin
          add_code_point(run, dec_accum);
          add_byte(run, b, 1'b1);
          dec_mode   = MODE_PLAIN;
          dec_digits = '0;
        end
      end
      MODE_ESC: begin
        if (b == CHAR_U) begin
          dec_mode   = MODE_HEX;
          dec_accum  = '0;
          dec_digits = '0;
        end else begin
          if (b == CHAR_N) begin
            add_byte(run, CHAR_LF, 1'b1);
          end else if (b == CHAR_R) begin
            add_byte(run, CHAR_CR, 1'b1);
          end else begin
            add_byte(run, CHAR_BACKSLASH, 1'b1);
            add_byte(run, b, 1'b1);
          end
          dec_mode = MODE_PLAIN;
        end
      end
      default: begin
        if (b == CHAR_BACKSLASH) dec_mode = MODE_ESC;
        else add_byte(run, b, 1'b1);
      end
    endcase
    close_run(run, fin);
    if (fin) begin
      dec_mode   = MODE_PLAIN;
      dec_accum  = '0;
      dec_digits = '0;
    end
  endfunction

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1) == 1) return 8'(8'h41 + v - 10);
    return 8'(8'h61 + v - 10);
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_digit_value(c) >= 0);
    return c;
  endfunction

  function automatic void push_char(ref stim_t q[$], input logic [7:0] c);
    stim_t s;
    s.data = c;
    s.fin  = 1'b0;
    q.push_back(s);
  endfunction

  // Builds one string out of escape sequences, plain text and some noise.
  function automatic void build_string(ref stim_t q[$]);
    int ntok;
    int kind;
    int digits;
    logic [7:0] c;
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 10);
      case (kind)
        0, 1, 2: begin
          c = 8'($urandom_range(0, 255));
          if (c == CHAR_BACKSLASH) c = 8'h5B;
          push_char(q, c);
        end
        3: begin
          push_char(q, CHAR_BACKSLASH);
          push_char(q, CHAR_N);
        end
        4: begin
          push_char(q, CHAR_BACKSLASH);
          push_char(q, CHAR_R);
        end
        5, 6, 7: begin
          push_char(q, CHAR_BACKSLASH);
          push_char(q, CHAR_U);
          digits = $urandom_range(0, 4);
          for (int k = 0; k < digits; k++) push_char(q, random_hex_char());
          if (digits < 4 && $urandom_range(0, 3) != 0) push_char(q, random_non_hex());
        end
        8: begin
          push_char(q, CHAR_BACKSLASH);
          push_char(q, 8'($urandom_range(0, 255)));
        end
        9: push_char(q, 8'($urandom_range(0, 255)));
        default: push_char(q, CHAR_BACKSLASH);
      endcase
    end
    q[q.size()-1].fin = 1'b1;
  endfunction

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(0, 255));
      s_tlast  <= 1'($urandom_range(0, 1));
    end
  endtask

  // Sender works in bursts; a burst ends with a random gap.
  task automatic pace();
    if (burst_left == 0) begin
      idle($urandom_range(1, 6));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Receiver: random phases of its own pattern, plus two long hold-offs
  // while the sender keeps offering requests.
  initial begin
    int cyc;
    int mode;
    int phase_left;
    cyc = 0;
    mode = 0;
    phase_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (phase_left == 0) begin
        mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      if ((cyc >= 300 && cyc < 420) || (cyc >= 1500 && cyc < 1620)) begin
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (cyc % 3 != 1);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_t got;
    out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata, m_tuser[0], m_tuser[1], m_tlast};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result data %h valid %b run_end %b str_end %b",
                 $time, got.data, got.valid, got.run_end, got.str_end);
      end else begin
        want = expected_q.pop_front();
        if (got.data !== want.data || got.valid !== want.valid ||
            got.run_end !== want.run_end || got.str_end !== want.str_end) begin
          errors++;
          $display("%0t: mismatch expected data %h valid %b run_end %b str_end %b",
                   $time, want.data, want.valid, want.run_end, want.str_end);
          $display("%0t:          actual   data %h valid %b run_end %b str_end %b",
                   $time, got.data, got.valid, got.run_end, got.str_end);
        end
      end
    end
  end

  initial begin
    stim_t rand_q[$];
    out_t  run[$];
    int    limit;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      pace();
      send_byte(ROWS[i].din, ROWS[i].fin);
      decode_step(ROWS[i].din, ROWS[i].fin, run);
      if (ROWS[i].typed) begin
        run.delete();
        if (ROWS[i].n > 0) add_byte(run, ROWS[i].d0, ROWS[i].ok);
        if (ROWS[i].n > 1) add_byte(run, ROWS[i].d1, 1'b1);
        close_run(run, ROWS[i].fin);
      end
      foreach (run[k]) expected_q.push_back(run[k]);
    end

    while (rand_q.size() < 450) build_string(rand_q);

    for (int i = 0; i < rand_q.size(); i++) begin
      // Halfway through, hold the next request until the output has drained.
      if (i == rand_q.size() / 2) begin
        idle(1);
        wait (expected_q.size() == 0);
      end
      pace();
      send_byte(rand_q[i].data, rand_q[i].fin);
      decode_step(rand_q[i].data, rand_q[i].fin, run);
      foreach (run[k]) expected_q.push_back(run[k]);
    end
    idle(1);

    limit = 0;
    while (expected_q.size() != 0 && limit < 100000) begin
      @(posedge clk);
      limit++;
    end
    repeat (16) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("escape_to_utf8_decoder_core verification clean");
    end else begin
      if (expected_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_q.size());
      $display("escape_to_utf8_decoder_core verification failed");
    end
    $finish;
  end

endmodule

// ----- escape_to_utf8_decoder_core.f -----
hdl/esc2u8_pkg.sv
hdl/esc2u8_decode.sv
hdl/escape_to_utf8_decoder_core.sv
bench/escape_to_utf8_decoder_core_test.sv
